// ===== hdl/smis_pkg.sv =====
// ----------------------------------------------------------------------------
// smis_pkg
// Shared constants, opcodes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package smis_pkg;

    localparam int MEM_WORDS  = 8192;
    localparam int PROG_WORDS = 512;
    localparam int AW  = $clog2(MEM_WORDS);
    localparam int SPW = $clog2(MEM_WORDS + 1);

    localparam logic [6:0] OP_POP   = 7'd0;
    localparam logic [6:0] OP_IPOP  = 7'd1;
    localparam logic [6:0] OP_PUSH  = 7'd2;
    localparam logic [6:0] OP_IPUSH = 7'd3;
    localparam logic [6:0] OP_PUSHI = 7'd4;
    localparam logic [6:0] OP_JMP   = 7'd5;
    localparam logic [6:0] OP_JNZ   = 7'd6;
    localparam logic [6:0] OP_CALL  = 7'd7;
    localparam logic [6:0] OP_RET   = 7'd8;
    localparam logic [6:0] OP_READ  = 7'd9;
    localparam logic [6:0] OP_WRITE = 7'd10;
    localparam logic [6:0] OP_ALU   = 7'd11;
    localparam logic [6:0] OP_RND   = 7'd12;
    localparam logic [6:0] OP_DUP   = 7'd13;
    localparam logic [6:0] OP_HALT  = 7'd99;

    localparam logic [3:0] ALU_EQ  = 4'd0;
    localparam logic [3:0] ALU_NE  = 4'd1;
    localparam logic [3:0] ALU_GE  = 4'd2;
    localparam logic [3:0] ALU_LE  = 4'd3;
    localparam logic [3:0] ALU_GT  = 4'd4;
    localparam logic [3:0] ALU_LT  = 4'd5;
    localparam logic [3:0] ALU_OR  = 4'd6;
    localparam logic [3:0] ALU_XOR = 4'd7;
    localparam logic [3:0] ALU_AND = 4'd8;
    localparam logic [3:0] ALU_NOT = 4'd9;
    localparam logic [3:0] ALU_ADD = 4'd10;
    localparam logic [3:0] ALU_SUB = 4'd11;
    localparam logic [3:0] ALU_MUL = 4'd12;
    localparam logic [3:0] ALU_DIV = 4'd13;
    localparam logic [3:0] ALU_MOD = 4'd14;
    localparam logic [3:0] ALU_NEG = 4'd15;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_HALT = 2'd1;
    localparam logic [1:0] ST_ERR  = 2'd2;

    // memory address source
    typedef enum logic [1:0] {
        A_SP_M1 = 2'd0,
        A_SP_M2 = 2'd1,
        A_OPND  = 2'd2,
        A_VALUE = 2'd3
    } t_asel;

    // register that captures read data
    typedef enum logic [1:0] {
        L_NONE = 2'd0,
        L_A    = 2'd1,
        L_B    = 2'd2
    } t_lsel;

    // commands from the controller
    typedef struct packed {
        logic       clear_step;
        logic [AW-1:0] clear_addr;
        logic       latch;
        t_asel      rd_sel;
        t_lsel      ld_sel;
        logic       div_start;
        logic       rnd;
        logic       finish;
    } t_cmd;

    // status back to the controller
    typedef struct packed {
        logic div_busy;
    } t_sts;

endpackage

// ===== hdl/smis_div.sv =====
// ----------------------------------------------------------------------------
// smis_div
// Iterative signed 16-bit divider, one quotient bit a cycle, truncating.
// ----------------------------------------------------------------------------
module smis_div import smis_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [15:0] i_num,
    input  logic [15:0] i_den,
    output logic        o_busy,
    output logic [15:0] o_quo,
    output logic [15:0] o_rem
);
    logic        r_busy;
    logic [4:0]  r_cnt;
    logic [15:0] r_q, r_d;
    logic [16:0] r_r;
    logic        r_nq, r_nr;
    logic [16:0] w_sh, w_sub;

    assign w_sh  = {r_r[15:0], r_q[15]};
    assign w_sub = w_sh - {1'b0, r_d};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= 5'd16;
        end else if (r_busy) begin
            r_cnt  <= r_cnt - 5'd1;
            r_busy <= (r_cnt != 5'd1);
        end
    end

    // restoring shift-subtract on magnitudes
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q  <= i_num[15] ? 16'(-i_num) : i_num;
            r_d  <= i_den[15] ? 16'(-i_den) : i_den;
            r_r  <= '0;
            r_nq <= i_num[15] ^ i_den[15];
            r_nr <= i_num[15];
        end else if (r_busy) begin
            if (!w_sub[16]) begin
                r_r <= w_sub;
                r_q <= {r_q[14:0], 1'b1};
            end else begin
                r_r <= w_sh;
                r_q <= {r_q[14:0], 1'b0};
            end
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_nq ? 16'(-r_q) : r_q;
    assign o_rem  = r_nr ? 16'(-r_r[15:0]) : r_r[15:0];
endmodule

// ===== hdl/smis_ctrl.sv =====
// ----------------------------------------------------------------------------
// smis_ctrl
// Controller: clearing pass, handshakes and memory read sequencing.
// ----------------------------------------------------------------------------
module smis_ctrl import smis_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [6:0]  i_opcode,
    input  logic [15:0] i_operand,
    output logic        o_valid,
    input  logic        i_ready,
    input  t_sts        i_sts,
    output t_cmd        o_cmd
);
    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_RD1   = 8'b0000_0100,
        S_RD2   = 8'b0000_1000,
        S_RD3   = 8'b0001_0000,
        S_DIV   = 8'b0010_0000,
        S_EXEC  = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } t_state;

    t_state        r_state, n_state;
    logic [AW-1:0] r_caddr;
    logic [6:0]    r_op;
    logic [15:0]   r_opnd;
    logic          w_acc;

    assign w_acc   = i_valid && o_ready;
    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_OUT);

    // state register and latched instruction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_caddr <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) r_caddr <= r_caddr + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_op   <= i_opcode;
            r_opnd <= i_operand;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_cmd.clear_addr = r_caddr;
        o_cmd.rd_sel = A_SP_M1;
        o_cmd.ld_sel = L_NONE;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                if (r_caddr == AW'(MEM_WORDS - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_cmd.latch = w_acc;
                if (w_acc) n_state = S_RD1;
            end
            S_RD1: begin
                // first read: top word, or operand address for push x / write
                if (r_op == OP_PUSH || r_op == OP_WRITE) o_cmd.rd_sel = A_OPND;
                else o_cmd.rd_sel = A_SP_M1;
                n_state = S_RD2;
            end
            S_RD2: begin
                o_cmd.ld_sel = L_B;
                if (r_op == OP_ALU) o_cmd.rd_sel = A_SP_M2;
                else if (r_op == OP_IPOP) o_cmd.rd_sel = A_SP_M2;
                else o_cmd.rd_sel = A_VALUE;
                n_state = S_RD3;
            end
            S_RD3: begin
                o_cmd.ld_sel = L_A;
                if ((r_op == OP_ALU && (r_opnd == 16'(ALU_DIV) || r_opnd == 16'(ALU_MOD)))
                    || r_op == OP_RND) begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.rnd = (r_op == OP_RND);
                    n_state = S_DIV;
                end else begin
                    n_state = S_EXEC;
                end
            end
            S_DIV: begin
                o_cmd.rnd = (r_op == OP_RND);
                if (!i_sts.div_busy) n_state = S_EXEC;
            end
            S_EXEC: begin
                o_cmd.finish = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

// ===== hdl/smis_dp.sv =====
// ----------------------------------------------------------------------------
// smis_dp
// Datapath: data memory, pc/sp registers, alu, divider and result register.
// ----------------------------------------------------------------------------
module smis_dp import smis_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    input  logic [6:0]  i_opcode,
    input  logic [15:0] i_operand,
    input  logic [15:0] i_read_value,
    input  logic [15:0] i_random_value,
    output logic [15:0] o_next_pc,
    output logic [13:0] o_stack_depth,
    output logic [1:0]  o_status,
    output logic        o_write_valid,
    output logic [15:0] o_write_value
);
    logic [15:0]    mem [MEM_WORDS];
    logic [15:0]    r_rdata;
    logic [15:0]    r_pc;
    logic [SPW-1:0] r_sp;
    logic [6:0]     r_op;
    logic [15:0]    r_d, r_rv, r_rn;
    logic [15:0]    r_a, r_b;

    // address computation
    logic [15:0]   w_spm1, w_spm2, w_raddr16;
    logic [AW-1:0] w_raddr;
    assign w_spm1 = 16'(r_sp) - 16'd1;
    assign w_spm2 = 16'(r_sp) - 16'd2;
    always_comb begin
        case (i_cmd.rd_sel)
            A_SP_M1: w_raddr16 = w_spm1;
            A_SP_M2: w_raddr16 = w_spm2;
            A_OPND:  w_raddr16 = r_d;
            A_VALUE: w_raddr16 = r_rdata;
            default: w_raddr16 = w_spm1;
        endcase
    end
    assign w_raddr = w_raddr16[AW-1:0];

    // divider
    logic        w_dbusy;
    logic [15:0] w_quo, w_rem;
    smis_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_cmd.div_start),
        .i_num  (i_cmd.rnd ? r_rn : r_rdata),
        .i_den  (i_cmd.rnd ? r_d : r_b),
        .o_busy (w_dbusy),
        .o_quo  (w_quo),
        .o_rem  (w_rem)
    );
    assign o_sts.div_busy = w_dbusy;

    // note: at S_RD3 r_rdata holds a (second of two reads), r_b holds b

    // operand capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_op <= i_opcode;
            r_d  <= i_operand;
            r_rv <= i_read_value;
            r_rn <= i_random_value;
        end
        if (i_cmd.ld_sel == L_B) r_b <= r_rdata;
        if (i_cmd.ld_sel == L_A) r_a <= r_rdata;
    end

    // execute: validity, results and memory write
    logic          w_pcok, w_dok, w_aok;
    logic [SPW:0]  w_s;
    logic [15:0]   w_pc1, w_rel, w_alu, w_rnd;
    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [15:0]   w_wdata;
    logic [1:0]    w_st;
    logic [15:0]   w_npc;
    logic [SPW-1:0] w_nsp;
    logic          w_wv;
    logic [15:0]   w_wval;
    logic signed [15:0] w_sa, w_sb;
    logic [31:0]   w_prod;

    assign w_s    = {1'b0, r_sp};
    assign w_pcok = !r_pc[15] && (r_pc < 16'(PROG_WORDS));
    assign w_dok  = !r_d[15] && (r_d < 16'(MEM_WORDS));
    assign w_pc1  = r_pc + 16'd1;
    assign w_rel  = w_pc1 + r_d;
    assign w_sa   = r_a;
    assign w_sb   = r_b;
    assign w_prod = r_a * r_b;
    // a: for ipop/ipush/ret/jnz first read is top word (in r_b)
    assign w_aok  = !r_b[15] && (r_b < 16'(MEM_WORDS));
    assign w_rnd  = ((w_rem[15] && !r_d[15]) || (!w_rem[15] && w_rem != 16'd0 && r_d[15]))
                    ? 16'(-w_rem) : w_rem;

    always_comb begin
        case (r_d[3:0])
            ALU_EQ:  w_alu = {15'd0, w_sa == w_sb};
            ALU_NE:  w_alu = {15'd0, w_sa != w_sb};
            ALU_GE:  w_alu = {15'd0, w_sa >= w_sb};
            ALU_LE:  w_alu = {15'd0, w_sa <= w_sb};
            ALU_GT:  w_alu = {15'd0, w_sa > w_sb};
            ALU_LT:  w_alu = {15'd0, w_sa < w_sb};
            ALU_OR:  w_alu = r_a | r_b;
            ALU_XOR: w_alu = r_a ^ r_b;
            ALU_AND: w_alu = r_a & r_b;
            ALU_NOT: w_alu = ~r_b;
            ALU_ADD: w_alu = r_a + r_b;
            ALU_SUB: w_alu = r_a - r_b;
            ALU_MUL: w_alu = w_prod[15:0];
            ALU_DIV: w_alu = w_quo;
            ALU_MOD: w_alu = w_rem;
            ALU_NEG: w_alu = 16'(-r_b);
            default: w_alu = '0;
        endcase
    end

    always_comb begin
        w_st = ST_OK; w_npc = w_pc1; w_nsp = r_sp; w_wv = 1'b0; w_wval = '0;
        w_we = 1'b0; w_waddr = '0; w_wdata = '0;
        if (!w_pcok) begin
            w_st = ST_ERR; w_npc = r_pc;
        end else begin
            case (r_op)
                OP_POP: if (w_dok && w_s >= 1) begin
                    w_nsp = SPW'(w_spm1); w_we = 1'b1; w_waddr = r_d[AW-1:0]; w_wdata = r_b;
                end else w_st = ST_ERR;
                OP_IPOP: if (w_s >= 2 && w_aok) begin
                    w_nsp = SPW'(w_spm2); w_we = 1'b1; w_waddr = r_b[AW-1:0]; w_wdata = r_a;
                end else w_st = ST_ERR;
                OP_PUSH: if (w_s + 1 < MEM_WORDS && w_dok) begin
                    w_nsp = r_sp + SPW'(1); w_we = 1'b1; w_waddr = r_sp[AW-1:0]; w_wdata = r_b;
                end else w_st = ST_ERR;
                OP_IPUSH: if (w_s >= 1 && w_aok) begin
                    w_we = 1'b1; w_waddr = w_spm1[AW-1:0]; w_wdata = r_a;
                end else w_st = ST_ERR;
                OP_PUSHI: if (w_s < MEM_WORDS) begin
                    w_nsp = r_sp + SPW'(1); w_we = 1'b1; w_waddr = r_sp[AW-1:0]; w_wdata = r_d;
                end else w_st = ST_ERR;
                OP_JMP: w_npc = w_rel;
                OP_JNZ: if (w_s >= 1) begin
                    w_nsp = SPW'(w_spm1); if (r_b != 16'd0) w_npc = w_rel;
                end else w_st = ST_ERR;
                OP_CALL: if (w_s < MEM_WORDS) begin
                    w_nsp = r_sp + SPW'(1); w_we = 1'b1; w_waddr = r_sp[AW-1:0];
                    w_wdata = w_pc1; w_npc = w_rel;
                end else w_st = ST_ERR;
                OP_RET: if (w_s >= 1) begin
                    w_nsp = SPW'(w_spm1); w_npc = r_b;
                end else w_st = ST_ERR;
                OP_READ: if (w_dok) begin
                    w_we = 1'b1; w_waddr = r_d[AW-1:0]; w_wdata = r_rv;
                end else w_st = ST_ERR;
                OP_WRITE: if (w_dok) begin
                    w_wv = 1'b1; w_wval = r_b;
                end else w_st = ST_ERR;
                OP_ALU: if (w_s >= 2) begin
                    if (r_d[15:4] != 12'd0) begin
                        w_st = ST_OK;
                    end else if ((r_d[3:0] == ALU_DIV || r_d[3:0] == ALU_MOD)
                                 && r_b == 16'd0) begin
                        w_st = ST_ERR; w_npc = r_pc;
                    end else if (r_d[3:0] == ALU_NOT || r_d[3:0] == ALU_NEG) begin
                        w_we = 1'b1; w_waddr = w_spm1[AW-1:0]; w_wdata = w_alu;
                    end else begin
                        w_we = 1'b1; w_waddr = w_spm2[AW-1:0]; w_wdata = w_alu;
                        w_nsp = SPW'(w_spm1);
                    end
                end else w_st = ST_ERR;
                OP_RND: if (w_s + 1 < MEM_WORDS) begin
                    if (r_d == 16'd0) begin
                        w_st = ST_ERR; w_npc = r_pc;
                    end else begin
                        w_nsp = r_sp + SPW'(1); w_we = 1'b1;
                        w_waddr = r_sp[AW-1:0]; w_wdata = w_rnd;
                    end
                end else w_st = ST_ERR;
                OP_DUP: if (w_s >= 1 && w_s < MEM_WORDS) begin
                    w_nsp = r_sp + SPW'(1); w_we = 1'b1; w_waddr = r_sp[AW-1:0]; w_wdata = r_b;
                end else w_st = ST_ERR;
                OP_HALT: w_st = ST_HALT;
                default: w_st = ST_ERR;
            endcase
        end
    end

    // data memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.clear_step) mem[i_cmd.clear_addr] <= '0;
        else if (i_cmd.finish && w_we) mem[w_waddr] <= w_wdata;
        r_rdata <= mem[w_raddr];
    end

    // architectural state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= '0;
            r_sp <= '0;
        end else if (i_cmd.finish) begin
            r_pc <= w_npc;
            r_sp <= w_nsp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            o_next_pc     <= w_npc;
            o_stack_depth <= 14'(w_nsp);
            o_status      <= w_st;
            o_write_valid <= w_wv;
            o_write_value <= w_wval;
        end
    end
endmodule

// ===== hdl/stack_machine_instruction_step_core.sv =====
// ----------------------------------------------------------------------------
// stack_machine_instruction_step_core
// One-instruction step of a 16-bit stack machine with an 8192-word stack memory.
// ----------------------------------------------------------------------------
// Usage: present one instruction request (opcode, operand, read and random
// samples) on the input channel with i_valid; it is taken when o_ready is
// high. The result (next pc, stack depth, status, written word) appears on
// the output channel with o_valid and holds until i_ready.
// Sequencing: each request passes the read states RD1, RD2 and RD3 on the
// data memory's registered read port, then an execute state; div, mod and
// rnd first wait in the bit-serial divider. One request is in flight at a
// time; the next is taken in the cycle after the result is delivered, and a
// stalled receiver stalls the input.
// Reset: pc and stack pointer clear at once, then a clearing pass zeroes all
// 8192 words of the data memory one word a cycle, during which o_ready is low.
// ----------------------------------------------------------------------------
module stack_machine_instruction_step_core import smis_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [6:0]  i_opcode,
    input  logic [15:0] i_operand,
    input  logic [15:0] i_read_value,
    input  logic [15:0] i_random_value,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_next_pc,
    output logic [13:0] o_stack_depth,
    output logic [1:0]  o_status,
    output logic        o_write_valid,
    output logic [15:0] o_write_value
);
    t_cmd w_cmd;
    t_sts w_sts;

    // controller
    smis_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_opcode (i_opcode),
        .i_operand(i_operand),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .i_sts    (w_sts),
        .o_cmd    (w_cmd)
    );

    // datapath
    smis_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_opcode      (i_opcode),
        .i_operand     (i_operand),
        .i_read_value  (i_read_value),
        .i_random_value(i_random_value),
        .o_next_pc     (o_next_pc),
        .o_stack_depth (o_stack_depth),
        .o_status      (o_status),
        .o_write_valid (o_write_valid),
        .o_write_value (o_write_value)
    );

    // no request taken while a result waits
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && o_valid)) else $error("ready while result pending");

    // status code always defined
    a_stat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status != 2'd3)) else $error("bad status");

    // write flag only with ok status
    a_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_write_valid) |-> (o_status == ST_OK)) else $error("write flag");
endmodule

// ===== tb/stack_machine_instruction_step_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stack_machine_instruction_step_core_tb
// Self-checking bench for the stack machine instruction step. A directed table
// covers empty-stack faults, bad addresses and opcodes, halt and division corner
// cases. Random programs follow, mostly well-formed and kept near the bottom of
// the stack, with random request and result gaps and walks of every ALU sub-op.
// Every result is compared with a behavioural model of the machine state in the bench.
// ----------------------------------------------------------------------------
module stack_machine_instruction_step_core_tb;
    import smis_pkg::*;

    localparam int WATCHDOG = 40000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [6:0]  i_opcode;
    logic [15:0] i_operand;
    logic [15:0] i_read_value;
    logic [15:0] i_random_value;
    logic        o_valid;
    logic        i_ready;
    logic [15:0] o_next_pc;
    logic [13:0] o_stack_depth;
    logic [1:0]  o_status;
    logic        o_write_valid;
    logic [15:0] o_write_value;

    typedef struct packed {
        logic [15:0] pc;
        logic [13:0] depth;
        logic [1:0]  status;
        logic        wvalid;
        logic [15:0] wvalue;
    } t_step_res;

    typedef struct {
        logic [6:0]  opc;
        logic [15:0] opnd;
        logic [15:0] rdv;
        logic [15:0] rnv;
        bit          fixed;
        t_step_res   res;
    } t_row;

    // machine state mirrored by the bench
    logic [15:0] mdl_pc;
    int          mdl_sp;
    logic [15:0] mdl_mem [MEM_WORDS];

    t_step_res step_q [$];
    int        fails;
    int        idle_cycles;
    bit        drained;

    stack_machine_instruction_step_core DUT (.*);

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        fails++;
    endtask

    function automatic int sx(input logic [15:0] v);
        return int'($signed(v));
    endfunction

    function automatic bit addr_good(input int a);
        return a >= 0 && a < MEM_WORDS;
    endfunction

    // execute one instruction on the mirrored state
    function automatic t_step_res exec_step(input logic [6:0] opc, input logic [15:0] opnd,
                                            input logic [15:0] rdv, input logic [15:0] rnv);
        t_step_res r;
        int d, s, a, b, v, q;
        logic [15:0] pc;
        bit bin;
        d = sx(opnd);
        s = mdl_sp;
        r = '0;
        r.status = ST_OK;
        pc = mdl_pc;
        if (sx(mdl_pc) < 0 || sx(mdl_pc) >= PROG_WORDS) begin
            r.status = ST_ERR;
        end else begin
            pc = mdl_pc + 16'd1;
            case (opc)
                OP_POP: if (addr_good(d) && s >= 1) begin
                    s--; mdl_mem[d] = mdl_mem[s];
                end else r.status = ST_ERR;
                OP_IPOP: if (s >= 2 && addr_good(sx(mdl_mem[s-1]))) begin
                    mdl_mem[sx(mdl_mem[s-1])] = mdl_mem[s-2]; s -= 2;
                end else r.status = ST_ERR;
                OP_PUSH: if (s + 1 < MEM_WORDS && addr_good(d)) begin
                    mdl_mem[s] = mdl_mem[d]; s++;
                end else r.status = ST_ERR;
                OP_IPUSH: if (s >= 1 && addr_good(sx(mdl_mem[s-1]))) begin
                    mdl_mem[s-1] = mdl_mem[sx(mdl_mem[s-1])];
                end else r.status = ST_ERR;
                OP_PUSHI: if (s < MEM_WORDS) begin
                    mdl_mem[s] = opnd; s++;
                end else r.status = ST_ERR;
                OP_JMP: pc = pc + opnd;
                OP_JNZ: if (s >= 1) begin
                    s--;
                    if (mdl_mem[s] != 16'd0) pc = pc + opnd;
                end else r.status = ST_ERR;
                OP_CALL: if (s < MEM_WORDS) begin
                    mdl_mem[s] = pc; s++; pc = pc + opnd;
                end else r.status = ST_ERR;
                OP_RET: if (s >= 1) begin
                    s--; pc = mdl_mem[s];
                end else r.status = ST_ERR;
                OP_READ: if (addr_good(d)) mdl_mem[d] = rdv;
                    else r.status = ST_ERR;
                OP_WRITE: if (addr_good(d)) begin
                    r.wvalid = 1'b1; r.wvalue = mdl_mem[d];
                end else r.status = ST_ERR;
                OP_ALU: if (s >= 2) begin
                    if (d >= 0 && d <= 15) begin
                        a = sx(mdl_mem[s-2]);
                        b = sx(mdl_mem[s-1]);
                        bin = 1'b1;
                        v = 0;
                        case (opnd[3:0])
                            ALU_EQ:  v = a == b;
                            ALU_NE:  v = a != b;
                            ALU_GE:  v = a >= b;
                            ALU_LE:  v = a <= b;
                            ALU_GT:  v = a > b;
                            ALU_LT:  v = a < b;
                            ALU_OR:  v = a | b;
                            ALU_XOR: v = a ^ b;
                            ALU_AND: v = a & b;
                            ALU_NOT: begin bin = 1'b0; v = ~b; end
                            ALU_ADD: v = a + b;
                            ALU_SUB: v = a - b;
                            ALU_MUL: v = a * b;
                            ALU_DIV: v = (b == 0) ? 0 : a / b;
                            ALU_MOD: v = (b == 0) ? 0 : a % b;
                            ALU_NEG: begin bin = 1'b0; v = -b; end
                            default: v = 0;
                        endcase
                        if ((opnd[3:0] == ALU_DIV || opnd[3:0] == ALU_MOD) && b == 0) begin
                            r.status = ST_ERR; pc = mdl_pc;
                        end else if (bin) begin
                            mdl_mem[s-2] = v[15:0]; s--;
                        end else begin
                            mdl_mem[s-1] = v[15:0];
                        end
                    end
                end else r.status = ST_ERR;
                OP_RND: if (s + 1 < MEM_WORDS) begin
                    if (d == 0) begin
                        r.status = ST_ERR; pc = mdl_pc;
                    end else begin
                        q = sx(rnv) % d;
                        if ((q < 0 && d > 0) || (q > 0 && d < 0)) q = -q;
                        mdl_mem[s] = q[15:0]; s++;
                    end
                end else r.status = ST_ERR;
                OP_DUP: if (s >= 1 && s < MEM_WORDS) begin
                    mdl_mem[s] = mdl_mem[s-1]; s++;
                end else r.status = ST_ERR;
                OP_HALT: r.status = ST_HALT;
                default: r.status = ST_ERR;
            endcase
        end
        mdl_pc = pc;
        mdl_sp = s;
        r.pc = pc;
        r.depth = 14'(s);
        return r;
    endfunction

    // send one request and queue its expected result
    task automatic send(input logic [6:0] opc, input logic [15:0] opnd,
                        input logic [15:0] rdv, input logic [15:0] rnv,
                        input bit fixed, input t_step_res want);
        t_step_res r;
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(1, 2);
        repeat (gap) @(posedge i_clk);
        i_valid        <= 1'b1;
        i_opcode       <= opc;
        i_operand      <= opnd;
        i_read_value   <= rdv;
        i_random_value <= rnv;
        r = exec_step(opc, opnd, rdv, rnv);
        if (fixed && r != want) begin
            $display("directed row disagrees with model at %0t", $realtime);
            fails++;
        end
        step_q.push_back(r);
        do @(posedge i_clk); while (!o_ready);
        i_valid <= 1'b0;
    endtask

    // result checking
    always @(posedge i_clk) begin
        t_step_res w;
        if (i_rst_n && o_valid && i_ready) begin
            if (step_q.size() == 0) begin
                $display("unexpected result at %0t", $realtime);
                fails++;
            end else begin
                w = step_q.pop_front();
                if (o_next_pc != w.pc) report("next_pc", o_next_pc, w.pc);
                if (o_stack_depth != w.depth) report("stack_depth", 16'(o_stack_depth), 16'(w.depth));
                if (o_status != w.status) report("status", 16'(o_status), 16'(w.status));
                if (o_write_valid != w.wvalid) report("write_valid", 16'(o_write_valid), 16'(w.wvalid));
                if (o_write_value != w.wvalue) report("write_value", o_write_value, w.wvalue);
            end
        end
    end

    // receiver stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) i_ready <= 1'b0;
        else if ($urandom_range(0, 30) == 0) i_ready <= 1'b0;
        else if ($urandom_range(0, 2) != 0) i_ready <= 1'b1;
    end

    // watchdog: reset clearing pass is covered by the limit
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // random instruction biased toward a valid low stack
    task automatic send_random();
        logic [6:0]  opc;
        logic [15:0] opnd;
        int k;
        int tgt;
        int top;
        k = $urandom_range(0, 99);
        opnd = 16'($urandom_range(0, 40));
        if (k < 8)       opc = OP_POP;
        else if (k < 13) opc = OP_IPOP;
        else if (k < 22) opc = OP_PUSH;
        else if (k < 27) opc = OP_IPUSH;
        else if (k < 42) begin opc = OP_PUSHI; opnd = 16'($urandom); end
        else if (k < 46) begin opc = OP_JMP; opnd = 16'($urandom_range(0, 6)) - 16'd3; end
        else if (k < 50) begin opc = OP_JNZ; opnd = 16'($urandom_range(0, 6)) - 16'd3; end
        else if (k < 53) begin opc = OP_CALL; opnd = 16'($urandom_range(0, 6)); end
        else if (k < 56) opc = OP_RET;
        else if (k < 61) opc = OP_READ;
        else if (k < 66) opc = OP_WRITE;
        else if (k < 82) begin opc = OP_ALU; opnd = 16'($urandom_range(0, 16)); end
        else if (k < 88) begin opc = OP_RND; opnd = 16'($urandom); end
        else if (k < 93) opc = OP_DUP;
        else if (k < 95) opc = OP_HALT;
        else begin
            opc = 7'($urandom); opnd = 16'($urandom);
        end
        // keep the program counter inside program memory, an invalid pc never recovers
        if (sx(mdl_pc) >= PROG_WORDS - 16) begin
            opc = OP_JMP; opnd = 16'(-sx(mdl_pc) - 1);
        end
        tgt = sx(mdl_pc) + 1 + sx(opnd);
        if ((opc == OP_JMP || opc == OP_JNZ || opc == OP_CALL) && (tgt < 0 || tgt >= PROG_WORDS))
            opnd = '0;
        if (opc == OP_RET && mdl_sp >= 1) begin
            top = sx(mdl_mem[mdl_sp - 1]);
            if (top < 0 || top >= PROG_WORDS) opc = OP_DUP;
        end
        send(opc, opnd, 16'($urandom), 16'($urandom), 1'b0, '0);
    endtask

    t_row dir_tbl [$];

    function automatic t_step_res rs(input int pc, input int dp, input logic [1:0] st);
        t_step_res r;
        r = '0;
        r.pc = 16'(pc); r.depth = 14'(dp); r.status = st;
        return r;
    endfunction

    function automatic t_row row(input logic [6:0] o, input logic [15:0] d,
                                 input bit fx, input t_step_res r);
        t_row t;
        t.opc = o; t.opnd = d; t.rdv = 16'h8001; t.rnv = 16'h7FFE; t.fixed = fx; t.res = r;
        return t;
    endfunction

    // stimulus
    initial begin
        int n;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_opcode = '0;
        i_operand = '0;
        i_read_value = '0;
        i_random_value = '0;
        fails = 0;
        idle_cycles = 0;
        drained = 1'b0;
        mdl_pc = '0;
        mdl_sp = 0;
        foreach (mdl_mem[j]) mdl_mem[j] = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table: empty stack faults, extremes, division corners
        dir_tbl.push_back(row(OP_POP,   16'd0,    1, rs(1, 0, ST_ERR)));
        dir_tbl.push_back(row(OP_RET,   16'd0,    1, rs(2, 0, ST_ERR)));
        dir_tbl.push_back(row(OP_ALU,   16'd10,   1, rs(3, 0, ST_ERR)));
        dir_tbl.push_back(row(OP_READ,  16'h8000, 1, rs(4, 0, ST_ERR)));
        dir_tbl.push_back(row(OP_WRITE, 16'd8192, 1, rs(5, 0, ST_ERR)));
        dir_tbl.push_back(row(7'd127,   16'd0,    1, rs(6, 0, ST_ERR)));
        dir_tbl.push_back(row(OP_HALT,  16'd0,    1, rs(7, 0, ST_HALT)));
        dir_tbl.push_back(row(OP_READ,  16'd8191, 0, '0));
        dir_tbl.push_back(row(OP_WRITE, 16'd8191, 0, '0));
        dir_tbl.push_back(row(OP_PUSHI, 16'h8000, 0, '0));
        dir_tbl.push_back(row(OP_PUSHI, 16'hFFFF, 0, '0));
        dir_tbl.push_back(row(OP_ALU,   16'd13,   0, '0));
        dir_tbl.push_back(row(OP_PUSHI, 16'h8000, 0, '0));
        dir_tbl.push_back(row(OP_PUSHI, 16'hFFFF, 0, '0));
        dir_tbl.push_back(row(OP_ALU,   16'd14,   0, '0));
        dir_tbl.push_back(row(OP_PUSHI, 16'd0,    0, '0));
        dir_tbl.push_back(row(OP_ALU,   16'd13,   0, '0));
        dir_tbl.push_back(row(OP_ALU,   16'd99,   0, '0));
        dir_tbl.push_back(row(OP_RND,   16'd0,    0, '0));
        dir_tbl.push_back(row(OP_RND,   16'hFFF9, 0, '0));
        dir_tbl.push_back(row(OP_IPUSH, 16'd0,    0, '0));
        dir_tbl.push_back(row(OP_DUP,   16'd0,    0, '0));
        dir_tbl.push_back(row(OP_IPOP,  16'd0,    0, '0));
        dir_tbl.push_back(row(OP_CALL,  16'd3,    0, '0));
        foreach (dir_tbl[j])
            send(dir_tbl[j].opc, dir_tbl[j].opnd, dir_tbl[j].rdv, dir_tbl[j].rnv,
                 dir_tbl[j].fixed, dir_tbl[j].res);

        // random programs
        n = 0;
        while (n < 1400) begin
            send_random();
            n++;
            if (n >= 700 && !drained) begin
                wait (step_q.size() == 0);
                drained = 1'b1;
            end
            if ($urandom_range(0, 199) == 0) begin
                // walk the ALU opcode across all sub-ops
                for (int j = 0; j < 16; j++) begin
                    send(OP_PUSHI, 16'($urandom), '0, '0, 1'b0, '0);
                    send(OP_PUSHI, 16'($urandom), '0, '0, 1'b0, '0);
                    send(OP_ALU, 16'(j), '0, '0, 1'b0, '0);
                end
                n += 48;
            end
        end

        // invalid pc: every later step faults and changes nothing
        send(OP_JMP, 16'h8000, '0, '0, 1'b0, '0);
        send(OP_PUSHI, 16'd5, '0, '0, 1'b0, '0);
        send(OP_JMP, 16'd0, '0, '0, 1'b0, '0);

        wait (step_q.size() == 0);
        repeat (60) @(posedge i_clk);
        if (fails == 0 && step_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
